// File: hw/rtl/iac_pkg.sv
// Package for the in-flight access coalescer: types, constants, op codes.
// No dependencies.
`default_nettype none
package iac_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_START = 3'd0, OP_FINISH = 3'd1, OP_LOCK = 3'd2, OP_CQUERY = 3'd3,
		OP_CCOMMIT = 3'd4, OP_AQUERY = 3'd5, OP_WQUERY = 3'd6, OP_NONE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOID = 2'd2, ST_BAD = 2'd3
	} status_t;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_BAD = 2'd3;

	// configuration register byte address
	localparam logic [1:0] ADDR_BSL = 2'd0;

	localparam logic [3:0] BSL_RESET = 4'd6;
	localparam logic [3:0] BSL_MIN = 4'd2;
	localparam logic [3:0] BSL_MAX = 4'd12;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND_A, S_FIND_B, S_SCAN, S_WALK, S_SHIFT, S_UNLINK, S_DONE
	} state_t;
endpackage
`default_nettype wire

// File: hw/rtl/inflight_access_coalescer_top.sv
// Top level of the in-flight access coalescer: age-ordered access table
// with a slot sequencer that visits one entry per cycle. Uses iac_pkg.
//
// channel  | direction | handshake          | payload
// in       | to block  | in_valid/in_stall  | req_type access_id address access_kind ref_id ref_valid
// out      | from blk  | out_valid/out_stall| found result_id status live_entries uncoalesced_entries
// cfg      | to block  | APB psel/penable   | block_size_log at address 0
//
// An item runs from the accepting cycle to the result transfer through its
// passes: each id lookup, scan, walk, shift and unlink pass visits one slot
// per cycle, and the id lookup, scan and unlink passes share the single slot
// compare unit.
// in_stall is high from acceptance until the result transfer completes.
// Reset clears valid/mark bits and the counters; id, block, kind and link
// payload need no reset. out_valid holds with its payload while out_stall.
`default_nettype none
module inflight_access_coalescer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] access_id,
	input  wire logic [31:0] address,
	input  wire logic [1:0]  access_kind,
	input  wire logic [31:0] ref_id,
	input  wire logic        ref_valid,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             found,
	output logic [31:0]      result_id,
	output logic [1:0]       status,
	output logic [4:0]       live_entries,
	output logic [4:0]       uncoalesced_entries,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int D = iac_pkg::TABLE_DEPTH;
	localparam int IW = iac_pkg::IDX_W;
	localparam int CW = iac_pkg::CNT_W;

	// table storage
	logic [D-1:0]  valid_q, started_q, merged_q, hasm_q;
	logic [31:0]   id_q [D];
	logic [29:0]   blk_q [D];
	logic [1:0]    kind_q [D];
	logic [31:0]   mid_q [D];
	logic [CW-1:0] occ_q, mcnt_q;
	logic [3:0]    bsl_q;

	// captured request
	iac_pkg::op_t op_q;
	logic [31:0] aid_q, rid_q;
	logic [29:0] rblk_q;
	logic [1:0]  rkind_q;
	logic        rval_q;

	// sequencer
	iac_pkg::state_t st_q, st_d, nxt;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] pa_q, pb_q;   // found positions (D means none)
	logic          any_q;
	logic          fnd_q;
	logic [31:0]   res_q;
	logic [1:0]    sts_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = {28'd0, bsl_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q <= iac_pkg::BSL_RESET;
		end else if (psel && penable && pwrite && paddr == iac_pkg::ADDR_BSL) begin
			if (pwdata[3:0] < iac_pkg::BSL_MIN) bsl_q <= iac_pkg::BSL_MIN;
			else if (pwdata[3:0] > iac_pkg::BSL_MAX) bsl_q <= iac_pkg::BSL_MAX;
			else bsl_q <= pwdata[3:0];
		end
	end

	// shared slot compare unit: one slot per cycle
	logic [IW-1:0] pi;
	logic          in_rng, id_hit_a, id_hit_b, blk_hit, older_ok;
	assign pi = ptr_q[IW-1:0];
	assign in_rng = ptr_q < occ_q;
	assign id_hit_a = in_rng && valid_q[pi] && id_q[pi] == aid_q;
	assign id_hit_b = in_rng && valid_q[pi] && id_q[pi] == rid_q;
	assign blk_hit = blk_q[pi] == rblk_q;
	assign older_ok = !rval_q || id_q[pi] < rid_q;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = st_q != iac_pkg::S_IDLE;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			iac_pkg::S_IDLE: if (accept) st_d = iac_pkg::S_FIND_A;
			iac_pkg::S_DONE: if (!out_stall) st_d = iac_pkg::S_IDLE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= iac_pkg::S_IDLE;
		else st_q <= nxt;
	end

	logic [31:0] shifted;
	assign shifted = address >> bsl_q;

	// datapath and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; started_q <= '0; merged_q <= '0; hasm_q <= '0;
			occ_q <= '0; mcnt_q <= '0; out_valid <= 1'b0;
		end else begin
			case (st_q)
				iac_pkg::S_IDLE: begin
					if (accept) begin
						op_q <= iac_pkg::op_t'(req_type);
						aid_q <= access_id; rid_q <= ref_id; rval_q <= ref_valid;
						rkind_q <= access_kind; rblk_q <= shifted[29:0];
						ptr_q <= '0; pa_q <= CW'(D); pb_q <= CW'(D); any_q <= 1'b0;
						fnd_q <= 1'b0; res_q <= '0; sts_q <= iac_pkg::ST_OK;
					end
				end
				iac_pkg::S_FIND_A: begin
					// ops completed in this state, and lookup of access_id
					if (op_q == iac_pkg::OP_START || op_q == iac_pkg::OP_NONE) begin
						if (op_q == iac_pkg::OP_NONE || rkind_q == iac_pkg::KIND_BAD)
							sts_q <= iac_pkg::ST_BAD;
						else if (occ_q >= CW'(D)) sts_q <= iac_pkg::ST_FULL;
						else begin
							valid_q[occ_q[IW-1:0]] <= 1'b1;
							id_q[occ_q[IW-1:0]] <= aid_q;
							blk_q[occ_q[IW-1:0]] <= rblk_q;
							kind_q[occ_q[IW-1:0]] <= rkind_q;
							started_q[occ_q[IW-1:0]] <= 1'b0;
							merged_q[occ_q[IW-1:0]] <= 1'b0;
							hasm_q[occ_q[IW-1:0]] <= 1'b0;
							mid_q[occ_q[IW-1:0]] <= '0;
							occ_q <= occ_q + 1'b1;
						end
						out_valid <= 1'b1;
					end else if (op_q == iac_pkg::OP_CQUERY
							&& rkind_q == iac_pkg::KIND_BAD) begin
						sts_q <= iac_pkg::ST_BAD; out_valid <= 1'b1;
					end else if (op_q == iac_pkg::OP_AQUERY) begin
						ptr_q <= '0;
					end else if (op_q == iac_pkg::OP_FINISH || op_q == iac_pkg::OP_LOCK
							|| op_q == iac_pkg::OP_CCOMMIT) begin
						if (id_hit_a && pa_q == CW'(D)) pa_q <= ptr_q;
						if (in_rng) ptr_q <= ptr_q + 1'b1;
					end else begin
						// query ops needing ref lookup: skip to B
						ptr_q <= '0;
					end
				end
				iac_pkg::S_FIND_B: begin
					if (id_hit_b && pb_q == CW'(D)) pb_q <= ptr_q;
					if (in_rng) ptr_q <= ptr_q + 1'b1;
				end
				iac_pkg::S_SCAN: begin
					// block match scan; address query keeps the first hit
					if (in_rng) begin
						if (blk_hit && older_ok) begin
							any_q <= 1'b1;
							if (op_q == iac_pkg::OP_AQUERY && !any_q) begin
								fnd_q <= 1'b1; res_q <= id_q[pi];
							end
						end
						ptr_q <= ptr_q + 1'b1;
					end
				end
				iac_pkg::S_WALK: begin
					// backward walk from tail; ptr holds candidate index + 1
					if (ptr_q != '0) begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				iac_pkg::S_SHIFT: begin
					if (ptr_q + 1'b1 < occ_q) begin
						valid_q[pi] <= valid_q[pi + 1'b1];
						id_q[pi] <= id_q[pi + 1'b1];
						blk_q[pi] <= blk_q[pi + 1'b1];
						kind_q[pi] <= kind_q[pi + 1'b1];
						started_q[pi] <= started_q[pi + 1'b1];
						merged_q[pi] <= merged_q[pi + 1'b1];
						hasm_q[pi] <= hasm_q[pi + 1'b1];
						mid_q[pi] <= mid_q[pi + 1'b1];
						ptr_q <= ptr_q + 1'b1;
					end else begin
						valid_q[pi] <= 1'b0; started_q[pi] <= 1'b0;
						merged_q[pi] <= 1'b0; hasm_q[pi] <= 1'b0;
						occ_q <= occ_q - 1'b1;
						ptr_q <= '0;
					end
				end
				iac_pkg::S_UNLINK: begin
					if (in_rng) begin
						if (hasm_q[pi] && mid_q[pi] == aid_q) hasm_q[pi] <= 1'b0;
						ptr_q <= ptr_q + 1'b1;
					end
				end
				iac_pkg::S_DONE: if (!out_stall) out_valid <= 1'b0;
				default: ;
			endcase

			// phase completions
			case (st_q)
				iac_pkg::S_FIND_A:
					if ((op_q == iac_pkg::OP_FINISH || op_q == iac_pkg::OP_LOCK
							|| op_q == iac_pkg::OP_CCOMMIT) && !in_rng) begin
						if (op_q == iac_pkg::OP_CCOMMIT) begin
							// master lookup follows
							ptr_q <= '0;
						end else if (pa_q == CW'(D)) begin
							sts_q <= iac_pkg::ST_NOID; out_valid <= 1'b1;
						end else if (op_q == iac_pkg::OP_LOCK) begin
							started_q[pa_q[IW-1:0]] <= 1'b1; out_valid <= 1'b1;
						end else begin
							if (merged_q[pa_q[IW-1:0]] && mcnt_q != '0)
								mcnt_q <= mcnt_q - 1'b1;
							ptr_q <= pa_q;
						end
					end
				iac_pkg::S_FIND_B:
					if (!in_rng) begin
						if (op_q == iac_pkg::OP_CCOMMIT) begin
							if (pa_q == CW'(D) || pb_q == CW'(D))
								sts_q <= iac_pkg::ST_NOID;
							else if (hasm_q[pb_q[IW-1:0]] || pa_q == pb_q)
								sts_q <= iac_pkg::ST_BAD;
							else begin
								if (!merged_q[pa_q[IW-1:0]]) begin
									merged_q[pa_q[IW-1:0]] <= 1'b1;
									mcnt_q <= mcnt_q + 1'b1;
								end
								hasm_q[pa_q[IW-1:0]] <= 1'b1;
								mid_q[pa_q[IW-1:0]] <= rid_q;
							end
							out_valid <= 1'b1;
						end else if (rval_q && pb_q == CW'(D)) begin
							sts_q <= iac_pkg::ST_NOID; out_valid <= 1'b1;
						end else if (op_q == iac_pkg::OP_WQUERY) begin
							ptr_q <= rval_q ? pb_q : occ_q;
						end else begin
							ptr_q <= '0;
						end
					end
				iac_pkg::S_SCAN:
					if (!in_rng) begin
						if (op_q == iac_pkg::OP_AQUERY) out_valid <= 1'b1;
						else begin
							ptr_q <= rval_q ? pb_q : occ_q;
							if (!any_q || (rval_q ? pb_q : occ_q) == '0)
								out_valid <= 1'b1;
						end
					end
				iac_pkg::S_WALK: begin
					if (ptr_q == '0) out_valid <= 1'b1;
					else begin
						// examine slot ptr-1
						if (op_q == iac_pkg::OP_WQUERY) begin
							if (kind_q[IW'(ptr_q - 1'b1)] == iac_pkg::KIND_STORE) begin
								fnd_q <= 1'b1; res_q <= id_q[IW'(ptr_q - 1'b1)];
								out_valid <= 1'b1;
							end
						end else if (rkind_q == iac_pkg::KIND_LOAD) begin
							if (kind_q[IW'(ptr_q - 1'b1)] != iac_pkg::KIND_LOAD)
								out_valid <= 1'b1;
							else if (blk_q[IW'(ptr_q - 1'b1)] == rblk_q) begin
								fnd_q <= 1'b1;
								res_q <= hasm_q[IW'(ptr_q - 1'b1)] ?
									mid_q[IW'(ptr_q - 1'b1)] : id_q[IW'(ptr_q - 1'b1)];
								out_valid <= 1'b1;
							end
						end else begin
							if (kind_q[IW'(ptr_q - 1'b1)] == rkind_q
									&& blk_q[IW'(ptr_q - 1'b1)] == rblk_q
									&& !started_q[IW'(ptr_q - 1'b1)]) begin
								fnd_q <= 1'b1;
								res_q <= hasm_q[IW'(ptr_q - 1'b1)] ?
									mid_q[IW'(ptr_q - 1'b1)] : id_q[IW'(ptr_q - 1'b1)];
							end
							out_valid <= 1'b1;
						end
					end
				end
				iac_pkg::S_UNLINK: if (!in_rng) out_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// state sequencing mirrors the phase completions above
	always_comb begin
		nxt = st_d;
		case (st_q)
			iac_pkg::S_FIND_A: begin
				if (op_q == iac_pkg::OP_START || op_q == iac_pkg::OP_NONE
						|| (op_q == iac_pkg::OP_CQUERY && rkind_q == iac_pkg::KIND_BAD))
					nxt = iac_pkg::S_DONE;
				else if (op_q == iac_pkg::OP_AQUERY) nxt = iac_pkg::S_SCAN;
				else if (op_q == iac_pkg::OP_CQUERY || op_q == iac_pkg::OP_WQUERY)
					nxt = iac_pkg::S_FIND_B;
				else if (in_rng) nxt = iac_pkg::S_FIND_A;
				else if (op_q == iac_pkg::OP_CCOMMIT) nxt = iac_pkg::S_FIND_B;
				else if (pa_q == CW'(D) || op_q == iac_pkg::OP_LOCK)
					nxt = iac_pkg::S_DONE;
				else nxt = iac_pkg::S_SHIFT;
			end
			iac_pkg::S_FIND_B: begin
				if (in_rng) nxt = iac_pkg::S_FIND_B;
				else if (op_q == iac_pkg::OP_CCOMMIT) nxt = iac_pkg::S_DONE;
				else if (rval_q && pb_q == CW'(D)) nxt = iac_pkg::S_DONE;
				else if (op_q == iac_pkg::OP_WQUERY) nxt = iac_pkg::S_WALK;
				else nxt = iac_pkg::S_SCAN;
			end
			iac_pkg::S_SCAN: begin
				if (in_rng) nxt = iac_pkg::S_SCAN;
				else if (op_q == iac_pkg::OP_AQUERY) nxt = iac_pkg::S_DONE;
				else if (!any_q || (rval_q ? pb_q : occ_q) == '0) nxt = iac_pkg::S_DONE;
				else nxt = iac_pkg::S_WALK;
			end
			iac_pkg::S_WALK: begin
				if (ptr_q == '0) nxt = iac_pkg::S_DONE;
				else if (op_q == iac_pkg::OP_WQUERY) begin
					if (kind_q[IW'(ptr_q - 1'b1)] == iac_pkg::KIND_STORE)
						nxt = iac_pkg::S_DONE;
				end else if (rkind_q == iac_pkg::KIND_LOAD) begin
					if (kind_q[IW'(ptr_q - 1'b1)] != iac_pkg::KIND_LOAD
							|| blk_q[IW'(ptr_q - 1'b1)] == rblk_q)
						nxt = iac_pkg::S_DONE;
				end else nxt = iac_pkg::S_DONE;
			end
			iac_pkg::S_SHIFT:
				nxt = (ptr_q + 1'b1 < occ_q) ? iac_pkg::S_SHIFT : iac_pkg::S_UNLINK;
			iac_pkg::S_UNLINK: nxt = in_rng ? iac_pkg::S_UNLINK : iac_pkg::S_DONE;
			default: ;
		endcase
	end

	// result outputs
	assign found = fnd_q;
	assign result_id = res_q;
	assign status = sts_q;
	assign live_entries = 5'(occ_q);
	assign uncoalesced_entries = (occ_q >= mcnt_q) ? 5'(occ_q - mcnt_q) : 5'd0;

	// assertions
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(D)) else $error("occupancy above depth");
	a_merged_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= occ_q) else $error("merged count above occupancy");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_found_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> result_id == 32'd0) else $error("id without hit");
	a_start_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == iac_pkg::S_FIND_A && op_q == iac_pkg::OP_START
		&& sts_q == iac_pkg::ST_OK && rkind_q != iac_pkg::KIND_BAD
		&& occ_q < CW'(D)) |=> occ_q == $past(occ_q) + 1'b1)
		else $error("start did not add entry");
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for inflight_access_coalescer_top.
// It keeps its own model of the access table, drives random and directed operations,
// and checks every result transfer. Depends on iac_pkg and the top level.
`timescale 1ns / 100ps
module tb;
	localparam logic [1:0] KIND_NCSTORE = 2'd2;
	localparam int DEPTH = iac_pkg::TABLE_DEPTH;

	typedef struct packed {
		logic             found;
		logic [31:0]      result_id;
		iac_pkg::status_t status;
		logic [4:0]       live;
		logic [4:0]       uncoalesced;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [31:0] access_id = '0;
	logic [31:0] address = '0;
	logic [1:0] access_kind = '0;
	logic [31:0] ref_id = '0;
	logic ref_valid = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [31:0] result_id;
	logic [1:0] status;
	logic [4:0] live_entries;
	logic [4:0] uncoalesced_entries;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	inflight_access_coalescer_top u_top (.*);

	// shadow copy of the access table
	logic [3:0]  shadow_bsl;
	logic [31:0] tbl_id [DEPTH];
	logic [29:0] tbl_block [DEPTH];
	logic [1:0]  tbl_kind [DEPTH];
	logic        tbl_started [DEPTH];
	logic        tbl_merged [DEPTH];
	logic        tbl_linked [DEPTH];
	logic [31:0] tbl_master [DEPTH];
	int          tbl_occ;
	int          tbl_merged_cnt;

	table_result_t pending_results[$];
	int  err_count = 0;
	bit  hold_receiver = 1'b0;
	bit  quiet = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 2000000);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int find_slot(logic [31:0] id);
		for (int i = 0; i < tbl_occ; i++)
			if (tbl_id[i] == id) return i;
		return DEPTH;
	endfunction

	function automatic logic [31:0] master_or_self(int p);
		return tbl_linked[p] ? tbl_master[p] : tbl_id[p];
	endfunction

	// table behavior for one operation
	function automatic table_result_t apply_op(logic [2:0] op, logic [31:0] id,
			logic [31:0] addr, logic [1:0] kind, logic [31:0] rid, logic rv);
		table_result_t r;
		logic [29:0] blk;
		int p, m, tail, i;
		bit any;
		r = '0;
		r.status = iac_pkg::ST_OK;
		blk = 30'(addr >> shadow_bsl);
		case (iac_pkg::op_t'(op))
			iac_pkg::OP_START: begin
				if (kind == iac_pkg::KIND_BAD) r.status = iac_pkg::ST_BAD;
				else if (tbl_occ >= DEPTH) r.status = iac_pkg::ST_FULL;
				else begin
					p = tbl_occ;
					tbl_id[p] = id; tbl_block[p] = blk; tbl_kind[p] = kind;
					tbl_started[p] = 0; tbl_merged[p] = 0; tbl_linked[p] = 0;
					tbl_master[p] = '0;
					tbl_occ++;
				end
			end
			iac_pkg::OP_FINISH: begin
				p = find_slot(id);
				if (p >= DEPTH) r.status = iac_pkg::ST_NOID;
				else begin
					if (tbl_merged[p] && tbl_merged_cnt > 0) tbl_merged_cnt--;
					for (i = p; i + 1 < tbl_occ; i++) begin
						tbl_id[i] = tbl_id[i+1]; tbl_block[i] = tbl_block[i+1];
						tbl_kind[i] = tbl_kind[i+1]; tbl_started[i] = tbl_started[i+1];
						tbl_merged[i] = tbl_merged[i+1]; tbl_linked[i] = tbl_linked[i+1];
						tbl_master[i] = tbl_master[i+1];
					end
					tbl_occ--;
					// drop links that pointed at the finished access
					for (i = 0; i < tbl_occ; i++)
						if (tbl_linked[i] && tbl_master[i] == id) tbl_linked[i] = 0;
				end
			end
			iac_pkg::OP_LOCK: begin
				p = find_slot(id);
				if (p >= DEPTH) r.status = iac_pkg::ST_NOID;
				else tbl_started[p] = 1;
			end
			iac_pkg::OP_CQUERY: begin
				any = 0;
				tail = tbl_occ;
				if (kind == iac_pkg::KIND_BAD) r.status = iac_pkg::ST_BAD;
				else begin
					if (rv) tail = find_slot(rid);
					if (rv && tail >= DEPTH) r.status = iac_pkg::ST_NOID;
					else begin
						for (i = 0; i < tbl_occ; i++)
							if (tbl_block[i] == blk && (!rv || tbl_id[i] < rid)) any = 1;
						if (any && tail != 0) begin
							if (kind == iac_pkg::KIND_LOAD) begin
								// walk back over trailing loads
								for (i = tail - 1; i >= 0; i--) begin
									if (tbl_kind[i] != iac_pkg::KIND_LOAD) break;
									if (tbl_block[i] == blk) begin
										r.found = 1; r.result_id = master_or_self(i);
										break;
									end
								end
							end else begin
								p = tail - 1;
								if (tbl_kind[p] == kind && tbl_block[p] == blk && !tbl_started[p]) begin
									r.found = 1; r.result_id = master_or_self(p);
								end
							end
						end
					end
				end
			end
			iac_pkg::OP_CCOMMIT: begin
				p = find_slot(id);
				m = find_slot(rid);
				if (p >= DEPTH || m >= DEPTH) r.status = iac_pkg::ST_NOID;
				else if (tbl_linked[m] || p == m) r.status = iac_pkg::ST_BAD;
				else begin
					if (!tbl_merged[p]) begin
						tbl_merged[p] = 1;
						tbl_merged_cnt++;
					end
					tbl_linked[p] = 1;
					tbl_master[p] = rid;
				end
			end
			iac_pkg::OP_AQUERY: begin
				for (i = 0; i < tbl_occ; i++)
					if (tbl_block[i] == blk && (!rv || tbl_id[i] < rid)) begin
						r.found = 1; r.result_id = tbl_id[i];
						break;
					end
			end
			iac_pkg::OP_WQUERY: begin
				tail = tbl_occ;
				if (rv) tail = find_slot(rid);
				if (rv && tail >= DEPTH) r.status = iac_pkg::ST_NOID;
				else
					for (i = tail - 1; i >= 0; i--)
						if (tbl_kind[i] == iac_pkg::KIND_STORE) begin
							r.found = 1; r.result_id = tbl_id[i];
							break;
						end
			end
			default: r.status = iac_pkg::ST_BAD;
		endcase
		r.live = 5'(tbl_occ);
		r.uncoalesced = 5'(tbl_occ >= tbl_merged_cnt ? tbl_occ - tbl_merged_cnt : 0);
		return r;
	endfunction

	// send one operation and record the expected result at acceptance
	task automatic send_op(logic [2:0] op, logic [31:0] id, logic [31:0] addr,
			logic [1:0] kind, logic [31:0] rid, logic rv);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		repeat (gap) @(posedge clk);
		req_type <= op; access_id <= id; address <= addr;
		access_kind <= kind; ref_id <= rid; ref_valid <= rv;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(apply_op(op, id, addr, kind, rid, rv));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every result is in, then let the block settle
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_bsl(logic [31:0] value);
		logic [3:0] v;
		drain();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= iac_pkg::ADDR_BSL; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		v = value[3:0];
		shadow_bsl = (v < iac_pkg::BSL_MIN) ? iac_pkg::BSL_MIN :
			(v > iac_pkg::BSL_MAX) ? iac_pkg::BSL_MAX : v;
		@(posedge clk);
	endtask

	// receiver: random stall per result, or a long hold when asked
	initial begin
		int n;
		forever begin
			n = quiet ? 0 : $urandom_range(0, 4);
			if (hold_receiver) n = 300;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		table_result_t e;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				err_count++;
			end else begin
				e = pending_results.pop_front();
				if (found !== e.found) begin
					$error("found: expected %0d, got %0d", e.found, found); err_count++;
				end
				if (result_id !== e.result_id) begin
					$error("result_id: expected %h, got %h", e.result_id, result_id);
					err_count++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status); err_count++;
				end
				if (live_entries !== e.live) begin
					$error("live_entries: expected %0d, got %0d", e.live, live_entries);
					err_count++;
				end
				if (uncoalesced_entries !== e.uncoalesced) begin
					$error("uncoalesced_entries: expected %0d, got %0d", e.uncoalesced,
						uncoalesced_entries);
					err_count++;
				end
			end
		end
	end

	// ids and addresses biased toward what is in the table
	function automatic logic [31:0] pick_id();
		if (tbl_occ > 0 && $urandom_range(0, 4) != 0) return tbl_id[$urandom_range(0, tbl_occ - 1)];
		if ($urandom_range(0, 3) == 0) return $urandom();
		return $urandom_range(0, 40);
	endfunction

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 3) == 0) return $urandom();
		return ($urandom_range(0, 3) << 12) | $urandom_range(0, 255);
	endfunction

	function automatic logic [1:0] pick_kind();
		return ($urandom_range(0, 19) == 0) ? iac_pkg::KIND_BAD : 2'($urandom_range(0, 2));
	endfunction

	task automatic test_start_kinds();
		send_op(iac_pkg::OP_START, 32'd10, 32'h0000_0000, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_START, 32'd11, 32'hFFFF_FFFF, iac_pkg::KIND_STORE, '0, 1'b0);
		send_op(iac_pkg::OP_START, 32'd12, 32'h0000_0010, KIND_NCSTORE, '0, 1'b0);
		send_op(iac_pkg::OP_START, 32'hFFFF_FFFF, 32'h0000_0020, iac_pkg::KIND_BAD, '0, 1'b0);
		send_op(iac_pkg::OP_NONE, '0, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_LOCK, 32'd99, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
	endtask

	task automatic test_coalesce();
		send_op(iac_pkg::OP_START, 32'd13, 32'h0000_0004, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0008, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0008, iac_pkg::KIND_LOAD, 32'd13, 1'b1);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0008, iac_pkg::KIND_LOAD, 32'd77, 1'b1);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0008, iac_pkg::KIND_BAD, '0, 1'b0);
		send_op(iac_pkg::OP_CCOMMIT, 32'd13, '0, iac_pkg::KIND_LOAD, 32'd10, 1'b0);
		send_op(iac_pkg::OP_CCOMMIT, 32'd12, '0, iac_pkg::KIND_LOAD, 32'd13, 1'b0);
		send_op(iac_pkg::OP_CCOMMIT, 32'd12, '0, iac_pkg::KIND_LOAD, 32'd12, 1'b0);
		send_op(iac_pkg::OP_CCOMMIT, 32'd55, '0, iac_pkg::KIND_LOAD, 32'd10, 1'b0);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0004, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0010, KIND_NCSTORE, 32'd13, 1'b1);
		send_op(iac_pkg::OP_LOCK, 32'd12, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_CQUERY, '0, 32'h0000_0010, KIND_NCSTORE, 32'd13, 1'b1);
	endtask

	task automatic test_queries();
		send_op(iac_pkg::OP_AQUERY, '0, 32'h0000_0000, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_AQUERY, '0, 32'h0000_0000, iac_pkg::KIND_LOAD, 32'd10, 1'b1);
		send_op(iac_pkg::OP_WQUERY, '0, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_WQUERY, '0, '0, iac_pkg::KIND_LOAD, 32'd11, 1'b1);
		send_op(iac_pkg::OP_WQUERY, '0, '0, iac_pkg::KIND_LOAD, 32'd88, 1'b1);
		send_op(iac_pkg::OP_FINISH, 32'd10, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_FINISH, 32'd10, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
	endtask

	task automatic test_full_table();
		while (tbl_occ < DEPTH)
			send_op(iac_pkg::OP_START, pick_id(), pick_addr(), pick_kind(), '0, 1'b0);
		send_op(iac_pkg::OP_START, 32'd1, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
		// full table with no older-than bound
		send_op(iac_pkg::OP_CQUERY, '0, pick_addr(), iac_pkg::KIND_LOAD, '0, 1'b0);
		send_op(iac_pkg::OP_WQUERY, '0, '0, iac_pkg::KIND_LOAD, '0, 1'b0);
	endtask

	task automatic random_op();
		int w;
		logic [2:0] op;
		w = $urandom_range(0, 99);
		if (w < 28 && tbl_occ < DEPTH) op = iac_pkg::OP_START;
		else if (w < 46) op = iac_pkg::OP_FINISH;
		else if (w < 54) op = iac_pkg::OP_LOCK;
		else if (w < 70) op = iac_pkg::OP_CQUERY;
		else if (w < 80) op = iac_pkg::OP_CCOMMIT;
		else if (w < 89) op = iac_pkg::OP_AQUERY;
		else if (w < 98) op = iac_pkg::OP_WQUERY;
		else op = ($urandom_range(0, 1) != 0) ? iac_pkg::OP_NONE : iac_pkg::OP_START;
		send_op(op, pick_id(), pick_addr(), pick_kind(), pick_id(), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_random(int n);
		repeat (n) random_op();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_receiver = 1'b1;
		repeat (6) random_op();
		hold_receiver = 1'b0;
		drain();
		quiet = 1'b1;
		test_random(40);
		quiet = 1'b0;
	endtask

	initial begin
		shadow_bsl = iac_pkg::BSL_RESET;
		tbl_occ = 0;
		tbl_merged_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_start_kinds();
		test_coalesce();
		test_queries();
		test_full_table();
		test_random(300);
		write_bsl(32'd0);
		test_random(300);
		write_bsl(32'hFFFF_FFFF);
		test_random(300);
		test_backpressure();
		write_bsl(32'd12);
		test_random(250);
		write_bsl(32'd2);
		test_random(250);
		write_bsl(32'd9);
		test_random(150);
		drain();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/iac_pkg.sv
hw/rtl/inflight_access_coalescer_top.sv
sim/tb.sv
